FILE: hdl/tpse_pkg.sv
// Shared types and constants for the touch pen sampler with its event queue.
`default_nettype none

package tpse_pkg;

    localparam int DEF_QUEUE_DEPTH      = 16;
    localparam int DEF_SAMPLES_PER_AXIS = 16;

    localparam int COORD_W = 13;
    localparam int DELAY_W = 16;
    localparam int WORD_W  = 16;
    localparam int WORD_SHIFT = 3;
    localparam int COUNT_OUT_W = 5;

    localparam logic [7:0] CMD_X    = 8'hD0;
    localparam logic [7:0] CMD_Y    = 8'h90;
    localparam logic [7:0] CMD_IDLE = 8'h00;

    typedef enum logic [1:0] {
        MODE_PEN_IRQ = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_WORD    = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PEN_UP      = 2'd0,
        PEN_PRESSED = 2'd1,
        PEN_MOVING  = 2'd2
    } pen_state_t;

    typedef enum logic {
        CFG_FIRST_DELAY  = 1'b0,
        CFG_REPEAT_DELAY = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        mode_t              mode;
        logic               pen_low;
        logic [WORD_W-1:0]  conv_word;
    } in_item_t;

    typedef struct packed {
        logic                   event_valid;
        logic [COORD_W-1:0]     event_x;
        logic [COORD_W-1:0]     event_y;
        logic [1:0]             event_status;
        logic [COUNT_OUT_W-1:0] queue_count;
        logic [7:0]             adc_command;
        logic                   overflow;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pen_state_t         status;
    } ev_entry_t;

endpackage

`default_nettype wire

FILE: hdl/touch_pen_sampler_event_queue.sv
// Top level: pen state tracking, ADC averaging and the event queue.
`default_nettype none

// Resistive touch pen sampler. Every input item (pen interrupt, timer tick,
// conversion word, read request) gives exactly one result item, and one item
// can be accepted in every clock cycle unless the output is stalled; the
// result enters the output register in the cycle after acceptance, and a new
// item is taken in the same cycle as the waiting result is taken. Queued
// events live in a RAM of QUEUE_DEPTH entries; an event is written in the
// cycle after the item that makes it (the axis average goes through a
// reciprocal multiply in the write cycle), and a read of that entry in the
// same cycle is forwarded. No clearing pass is needed after reset: the fill
// count gates every read. adc_command tells which axis the next conversion word
// must belong to. Write the two delay registers only while the block is idle.
module touch_pen_sampler_event_queue #(
    parameter int QUEUE_DEPTH      = tpse_pkg::DEF_QUEUE_DEPTH,
    parameter int SAMPLES_PER_AXIS = tpse_pkg::DEF_SAMPLES_PER_AXIS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire tpse_pkg::in_item_t                   in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output tpse_pkg::out_item_t                       out_item,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire tpse_pkg::cfg_reg_t                   cfg_index,
    input  wire logic [tpse_pkg::DELAY_W-1:0]         cfg_data
);

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int PW       = $clog2(SAMPLES_PER_AXIS + 1);
    localparam int LOG_S    = $clog2(SAMPLES_PER_AXIS);
    localparam int ACC_W    = tpse_pkg::COORD_W + LOG_S;
    localparam int RECIP_W  = ACC_W + 2;
    localparam int PROD_W   = ACC_W + RECIP_W;
    localparam int DIV_SHIFT = ACC_W + LOG_S;
    localparam int ENTRY_W  = $bits(tpse_pkg::ev_entry_t);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) / SAMPLES_PER_AXIS) + 64'd1);

    // configuration
    logic [tpse_pkg::DELAY_W-1:0] first_delay_reg, first_delay_next;
    logic [tpse_pkg::DELAY_W-1:0] repeat_delay_reg, repeat_delay_next;

    // pen and sampling state
    tpse_pkg::pen_state_t         pen_state_reg, pen_state_next;
    logic                         sampling_reg, sampling_next;
    logic [tpse_pkg::DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic                         timer_armed_reg, timer_armed_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic                         axis_y_reg, axis_y_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [tpse_pkg::COORD_W-1:0] last_x_reg, last_x_next;
    logic [tpse_pkg::COORD_W-1:0] last_y_reg, last_y_next;

    // queue pointers
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // post stage: average and queue write
    logic                 p_valid_reg, p_valid_next;
    logic                 p_is_div_reg, p_is_div_next;
    logic                 p_axis_y_reg, p_axis_y_next;
    logic                 p_push_reg, p_push_next;
    tpse_pkg::pen_state_t p_st_reg, p_st_next;
    logic [AW-1:0]        p_addr_reg, p_addr_next;
    logic [ACC_W-1:0]     p_acc_reg, p_acc_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [CW-1:0]        res_count_reg;
    logic [7:0]           res_cmd_reg, res_cmd_next;
    logic                 res_ovf_reg, res_ovf_next;
    logic                 fwd_hit_reg, fwd_hit_next;
    tpse_pkg::ev_entry_t  fwd_data_reg;

    logic                 in_accept;
    logic                 out_take;
    logic                 rd_en;
    logic                 ram_we;
    tpse_pkg::ev_entry_t  ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    tpse_pkg::ev_entry_t  rd_entry;
    logic [PROD_W-1:0]    prod;
    logic [tpse_pkg::COORD_W-1:0] quot;
    logic [ACC_W-1:0]     acc_sum;
    logic                 push_req;
    tpse_pkg::pen_state_t push_st;
    logic                 div_start;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    assign prod = PROD_W'(p_acc_reg) * PROD_W'(RECIP);
    assign quot = prod[DIV_SHIFT +: tpse_pkg::COORD_W];

    assign ram_we       = p_valid_reg && p_push_reg;
    assign ram_wdata.x  = last_x_reg;
    assign ram_wdata.y  = (p_is_div_reg && p_axis_y_reg) ? quot : last_y_reg;
    assign ram_wdata.status = p_st_reg;

    tpse_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p_addr_reg),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        first_delay_next  = first_delay_reg;
        repeat_delay_next = repeat_delay_reg;
        pen_state_next    = pen_state_reg;
        sampling_next     = sampling_reg;
        delay_count_next  = delay_count_reg;
        timer_armed_next  = timer_armed_reg;
        pos_next          = pos_reg;
        axis_y_next       = axis_y_reg;
        acc_next          = acc_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        count_next        = count_reg;
        push_req          = 1'b0;
        push_st           = tpse_pkg::PEN_UP;
        div_start         = 1'b0;
        rd_en             = 1'b0;
        res_ovf_next      = 1'b0;
        acc_sum = acc_reg + ((pos_reg != '0)
            ? ACC_W'(in_item.conv_word[tpse_pkg::WORD_W-1:tpse_pkg::WORD_SHIFT])
            : ACC_W'(0));

        p_valid_next  = 1'b0;
        p_is_div_next = 1'b0;
        p_axis_y_next = axis_y_reg;
        p_push_next   = 1'b0;
        p_st_next     = pen_state_reg;
        p_addr_next   = wr_ptr_reg;
        p_acc_next    = acc_sum;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpse_pkg::CFG_FIRST_DELAY:  first_delay_next  = cfg_data;
                tpse_pkg::CFG_REPEAT_DELAY: repeat_delay_next = cfg_data;
                default: ;
            endcase
        end

        if (p_valid_reg && p_is_div_reg)
        begin
            if (p_axis_y_reg)
            begin
                last_y_next = quot;
            end
            else
            begin
                last_x_next = quot;
            end
        end

        if (in_accept)
        begin
            unique case (in_item.mode)
                tpse_pkg::MODE_PEN_IRQ:
                begin
                    if (pen_state_reg == tpse_pkg::PEN_UP && in_item.pen_low && !sampling_reg)
                    begin
                        pen_state_next   = tpse_pkg::PEN_PRESSED;
                        delay_count_next = first_delay_reg;
                        timer_armed_next = 1'b1;
                    end
                end
                tpse_pkg::MODE_TICK:
                begin
                    if (timer_armed_reg && !sampling_reg)
                    begin
                        if (delay_count_reg <= tpse_pkg::DELAY_W'(1))
                        begin
                            delay_count_next = '0;
                            timer_armed_next = 1'b0;
                            if (in_item.pen_low)
                            begin
                                sampling_next = 1'b1;
                                pos_next      = '0;
                                axis_y_next   = 1'b0;
                                acc_next      = '0;
                            end
                            else
                            begin
                                pen_state_next = tpse_pkg::PEN_UP;
                                push_req       = 1'b1;
                                push_st        = tpse_pkg::PEN_UP;
                            end
                        end
                        else
                        begin
                            delay_count_next = delay_count_reg - 1'b1;
                        end
                    end
                end
                tpse_pkg::MODE_WORD:
                begin
                    if (sampling_reg)
                    begin
                        if (pos_reg == PW'(SAMPLES_PER_AXIS))
                        begin
                            pos_next  = '0;
                            acc_next  = '0;
                            div_start = 1'b1;
                            if (!axis_y_reg)
                            begin
                                axis_y_next = 1'b1;
                            end
                            else
                            begin
                                axis_y_next      = 1'b0;
                                sampling_next    = 1'b0;
                                push_req         = 1'b1;
                                push_st          = pen_state_reg;
                                pen_state_next   = tpse_pkg::PEN_MOVING;
                                delay_count_next = repeat_delay_reg;
                                timer_armed_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                            acc_next = acc_sum;
                        end
                    end
                end
                tpse_pkg::MODE_READ:
                begin
                    if (count_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase

            if (push_req)
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res_ovf_next = 1'b1;
                end
                else
                begin
                    p_push_next = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            p_is_div_next = div_start;
            p_st_next     = push_st;
            p_valid_next  = div_start || p_push_next;
        end
    end

    // result fields
    always_comb
    begin
        out_valid_next = in_accept ? 1'b1 : (out_take ? 1'b0 : out_valid_reg);
        ev_valid_next  = rd_en;
        fwd_hit_next   = rd_en && ram_we && (p_addr_reg == rd_ptr_reg);
        if (sampling_next)
        begin
            res_cmd_next = axis_y_next ? tpse_pkg::CMD_Y : tpse_pkg::CMD_X;
        end
        else
        begin
            res_cmd_next = tpse_pkg::CMD_IDLE;
        end

        rd_entry = fwd_hit_reg ? fwd_data_reg : tpse_pkg::ev_entry_t'(ram_rdata);
        out_item.event_valid  = ev_valid_reg;
        out_item.event_x      = ev_valid_reg ? rd_entry.x : '0;
        out_item.event_y      = ev_valid_reg ? rd_entry.y : '0;
        out_item.event_status = ev_valid_reg ? rd_entry.status : tpse_pkg::PEN_UP;
        out_item.queue_count  = tpse_pkg::COUNT_OUT_W'(res_count_reg);
        out_item.adc_command  = res_cmd_reg;
        out_item.overflow     = res_ovf_reg;
        out_valid             = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg  <= tpse_pkg::DELAY_W'(5);
            repeat_delay_reg <= tpse_pkg::DELAY_W'(10);
            pen_state_reg    <= tpse_pkg::PEN_UP;
            sampling_reg     <= 1'b0;
            delay_count_reg  <= '0;
            timer_armed_reg  <= 1'b0;
            pos_reg          <= '0;
            axis_y_reg       <= 1'b0;
            acc_reg          <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            p_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_delay_reg  <= first_delay_next;
            repeat_delay_reg <= repeat_delay_next;
            pen_state_reg    <= pen_state_next;
            sampling_reg     <= sampling_next;
            delay_count_reg  <= delay_count_next;
            timer_armed_reg  <= timer_armed_next;
            pos_reg          <= pos_next;
            axis_y_reg       <= axis_y_next;
            acc_reg          <= acc_next;
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
            p_valid_reg      <= p_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_is_div_reg <= p_is_div_next;
        p_axis_y_reg <= p_axis_y_next;
        p_push_reg   <= p_push_next;
        p_st_reg     <= p_st_next;
        p_addr_reg   <= p_addr_next;
        p_acc_reg    <= p_acc_next;
        if (in_accept)
        begin
            ev_valid_reg  <= ev_valid_next;
            res_count_reg <= count_next;
            res_cmd_reg   <= res_cmd_next;
            res_ovf_reg   <= res_ovf_next;
        end
        if (rd_en)
        begin
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= ram_wdata;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_sampling_no_timer: assert property (@(posedge clk) disable iff (!rst_n)
        sampling_reg |-> !timer_armed_reg)
        else $error("timer armed during sampling");

    a_post_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(in_accept))
        else $error("post stage active without an accepted item");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_ovf_reg) |-> count_reg == CW'(QUEUE_DEPTH))
        else $error("overflow reported with room in queue");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> count_reg != '0)
        else $error("read from empty queue");

endmodule

`default_nettype wire

FILE: hdl/tpse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tpse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
